>>> hw/rtl/vtp_pkg.sv
// Shared types, codes and defaults for the vertex transform and projection block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package vtp_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int SCREEN_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XSCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XOFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YSCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_YOFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DSCALE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT = 3'd6;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    localparam logic SEL_MODEL  = 1'b0;
    localparam logic SEL_CAMERA = 1'b1;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_MODEL = 3'd1;
    localparam logic [2:0] OP_CAM   = 3'd2;
    localparam logic [2:0] OP_DEN   = 3'd3;
    localparam logic [2:0] OP_SX    = 3'd4;
    localparam logic [2:0] OP_SY    = 3'd5;
    localparam logic [2:0] OP_SD    = 3'd6;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] row;
        logic [1:0] col;
        logic       capture;
        logic       clip;
        logic       div_start;
        logic       div_sel;
        logic       out_load;
    } vtp_cmd_t;

    typedef struct packed {
        logic drawn;
        logic div_done;
    } vtp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/vtp_div.sv
// Radix-2 restoring divider for the perspective divide, one quotient bit per cycle.
// Depends on nothing; instantiated by the datapath.
`default_nettype none

module vtp_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quot
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] qm_reg, qm_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   ad_reg, ad_next;
    logic          neg_reg, neg_next;
    logic          dzero_reg, dzero_next;
    logic          nzero_reg, nzero_next;
    logic          nneg_reg, nneg_next;

    logic [31:0] abs_num;
    logic [31:0] abs_den;
    logic [32:0] rem_sh;
    logic        ge;

    assign abs_num = num[31] ? (~num + 32'd1) : num;
    assign abs_den = den[31] ? (~den + 32'd1) : den;
    assign rem_sh  = {rem_reg[31:0], n_reg[NW-1]};
    assign ge      = rem_sh >= {1'b0, ad_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        qm_next    = qm_reg;
        rem_next   = rem_reg;
        ad_next    = ad_reg;
        neg_next   = neg_reg;
        dzero_next = dzero_reg;
        nzero_next = nzero_reg;
        nneg_next  = nneg_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CW'(NW);
            n_next     = {abs_num, {FRAC_BITS{1'b0}}};
            qm_next    = '0;
            rem_next   = '0;
            ad_next    = abs_den;
            neg_next   = num[31] ^ den[31];
            dzero_next = (den == 32'sd0);
            nzero_next = (num == 32'sd0);
            nneg_next  = num[31];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, ad_reg}) : rem_sh;
            qm_next  = {qm_reg[NW-2:0], ge};
            n_next   = {n_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        qm_reg    <= qm_next;
        rem_reg   <= rem_next;
        ad_reg    <= ad_next;
        neg_reg   <= neg_next;
        dzero_reg <= dzero_next;
        nzero_reg <= nzero_next;
        nneg_reg  <= nneg_next;
    end

    always_comb
    begin
        if (dzero_reg)
        begin
            if (nzero_reg)
                quot = 32'sd0;
            else if (nneg_reg)
                quot = 32'h8000_0000;
            else
                quot = 32'h7FFF_FFFF;
        end
        else if (neg_reg)
        begin
            if ((qm_reg[NW-1:32] != '0) || (qm_reg[31] && (qm_reg[30:0] != '0)))
                quot = 32'h8000_0000;
            else
                quot = ~qm_reg[31:0] + 32'd1;
        end
        else
        begin
            if (qm_reg[NW-1:31] != '0)
                quot = 32'h7FFF_FFFF;
            else
                quot = qm_reg[31:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/vtp_dp.sv
// Datapath: matrix and register storage, shared multiplier with accumulator,
// clip logic, the divider and the result register. Depends on vtp_pkg and vtp_div.
`default_nettype none

module vtp_dp
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire vtp_cmd_t               cmd,
    output vtp_stat_t                   stat,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [31:0]            cfg_wdata,
    input  wire logic                   in_cmd,
    input  wire logic                   in_msel,
    input  wire logic [3:0]             in_entry_index,
    input  wire logic signed [31:0]     in_entry_value,
    input  wire logic signed [31:0]     in_vx,
    input  wire logic signed [31:0]     in_vy,
    input  wire logic signed [31:0]     in_vz,
    output logic signed [31:0]          world_x,
    output logic signed [31:0]          world_y,
    output logic signed [31:0]          world_z,
    output logic signed [SCREEN_BITS-1:0] screen_x,
    output logic signed [SCREEN_BITS-1:0] screen_y,
    output logic signed [SCREEN_BITS-1:0] screen_depth,
    output logic                        in_bounds,
    output logic                        drawn
);

    localparam logic signed [31:0] ONE      = 32'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [32:0] ONE33    = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [32:0] NEG_ONE  = -ONE33;
    localparam logic signed [32:0] FAR      = -(33'sd50 <<< FRAC_BITS);
    localparam logic signed [66:0] S_HI     = (67'sd1 <<< (SCREEN_BITS - 1)) - 67'sd1;
    localparam logic signed [66:0] S_LO     = -S_HI - 67'sd1;
    localparam logic signed [66:0] RND      = (67'sd1 <<< FRAC_BITS) - 67'sd1;
    localparam logic signed [66:0] SAT_HI   = 67'sh7FFF_FFFF;
    localparam logic signed [66:0] SAT_LO   = -SAT_HI - 67'sd1;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_LO)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [SCREEN_BITS-1:0] to_screen(input logic signed [66:0] v);
        logic signed [66:0] t;
        logic signed [SCREEN_BITS-1:0] r;
        t = (v + (v[66] ? RND : 67'sd0)) >>> FRAC_BITS;
        if (t > S_HI)
            r = S_HI[SCREEN_BITS-1:0];
        else if (t < S_LO)
            r = S_LO[SCREEN_BITS-1:0];
        else
            r = t[SCREEN_BITS-1:0];
        return r;
    endfunction

    logic signed [31:0] model_reg [16];
    logic signed [31:0] camm_reg  [16];
    logic signed [31:0] focal_reg, xscale_reg, xoff_reg, yscale_reg, yoff_reg, dscale_reg;
    logic               reject_reg;

    logic signed [31:0] obj_reg   [3];
    logic signed [31:0] world_reg [4];
    logic signed [31:0] camv_reg  [4];
    logic signed [31:0] zc_reg;
    logic signed [31:0] den_reg;
    logic signed [31:0] qx_reg, qy_reg;
    logic signed [SCREEN_BITS-1:0] sx_reg, sy_reg, sd_reg;
    logic               inb_reg, drawn_reg;

    logic signed [64:0] fl_reg;
    logic signed [66:0] acc_reg;
    logic [2:0]         op_d_reg;
    logic [1:0]         row_d_reg, col_d_reg;

    logic signed [32:0] op_a;
    logic signed [31:0] op_b;
    logic signed [31:0] obj_sel;
    logic signed [64:0] prod;
    logic signed [66:0] acc_sum;
    logic signed [66:0] fl_ext;
    logic [3:0]         m_idx;
    logic signed [32:0] zs;
    logic               inb_w, drawn_w;
    logic signed [31:0] div_num;
    logic               div_done;
    logic signed [31:0] div_q;

    assign m_idx  = {cmd.row, cmd.col};
    assign obj_sel = (cmd.row == 2'd3) ? ONE : obj_reg[cmd.row];

    always_comb
    begin
        case (cmd.op)
            OP_MODEL:
            begin
                op_a = 33'(obj_sel);
                op_b = model_reg[m_idx];
            end
            OP_CAM:
            begin
                op_a = 33'(world_reg[cmd.row]);
                op_b = camm_reg[m_idx];
            end
            OP_DEN:
            begin
                op_a = -33'(focal_reg);
                op_b = zc_reg;
            end
            OP_SX:
            begin
                op_a = 33'(qx_reg);
                op_b = xscale_reg;
            end
            OP_SY:
            begin
                op_a = 33'(qy_reg);
                op_b = yscale_reg;
            end
            OP_SD:
            begin
                op_a = 33'(zc_reg);
                op_b = dscale_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod    = 65'(op_a) * 65'(op_b);
    assign fl_ext  = 67'(fl_reg);
    assign acc_sum = ((row_d_reg == 2'd0) ? 67'sd0 : acc_reg) + fl_ext;

    assign zs      = 33'(camv_reg[2]);
    assign inb_w   = (zs >= FAR) && (zs < NEG_ONE);
    assign drawn_w = inb_w || !reject_reg;

    assign div_num = cmd.div_sel ? camv_reg[1] : camv_reg[0];

    vtp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign stat.drawn    = drawn_w;
    assign stat.div_done = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                model_reg[i] <= ((i % 5) == 0) ? ONE : 32'sd0;
                camm_reg[i]  <= ((i % 5) == 0) ? ONE : 32'sd0;
            end
            focal_reg  <= ONE;
            xscale_reg <= ONE;
            xoff_reg   <= 32'sd0;
            yscale_reg <= ONE;
            yoff_reg   <= 32'sd0;
            dscale_reg <= ONE;
            reject_reg <= 1'b0;
            op_d_reg   <= OP_NONE;
            row_d_reg  <= 2'd0;
            col_d_reg  <= 2'd0;
        end
        else
        begin
            op_d_reg  <= cmd.op;
            row_d_reg <= cmd.row;
            col_d_reg <= cmd.col;
            if (cmd.capture && (in_cmd == CMD_LOAD))
            begin
                if (in_msel == SEL_CAMERA)
                    camm_reg[in_entry_index] <= in_entry_value;
                else
                    model_reg[in_entry_index] <= in_entry_value;
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_FOCAL:  focal_reg  <= cfg_wdata;
                    CFG_XSCALE: xscale_reg <= cfg_wdata;
                    CFG_XOFF:   xoff_reg   <= cfg_wdata;
                    CFG_YSCALE: yscale_reg <= cfg_wdata;
                    CFG_YOFF:   yoff_reg   <= cfg_wdata;
                    CFG_DSCALE: dscale_reg <= cfg_wdata;
                    CFG_REJECT: reject_reg <= cfg_wdata[0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fl_reg <= prod >>> FRAC_BITS;
        if (cmd.capture && (in_cmd == CMD_VERTEX))
        begin
            obj_reg[0] <= in_vx;
            obj_reg[1] <= in_vy;
            obj_reg[2] <= in_vz;
        end
        case (op_d_reg)
            OP_MODEL:
            begin
                acc_reg <= acc_sum;
                if (row_d_reg == 2'd3)
                    world_reg[col_d_reg] <= sat32(acc_sum);
            end
            OP_CAM:
            begin
                acc_reg <= acc_sum;
                if (row_d_reg == 2'd3)
                    camv_reg[col_d_reg] <= sat32(acc_sum);
            end
            OP_DEN: den_reg <= sat32(fl_ext);
            OP_SX:  sx_reg  <= to_screen(fl_ext + 67'(xoff_reg));
            OP_SY:  sy_reg  <= to_screen(fl_ext + 67'(yoff_reg));
            OP_SD:  sd_reg  <= to_screen(fl_ext);
            default: ;
        endcase
        if (cmd.clip)
        begin
            inb_reg   <= inb_w;
            drawn_reg <= drawn_w;
            zc_reg    <= (zs > NEG_ONE) ? NEG_ONE[31:0] : camv_reg[2];
            if (!drawn_w)
            begin
                sx_reg <= '0;
                sy_reg <= '0;
                sd_reg <= '0;
            end
        end
        if (div_done)
        begin
            if (cmd.div_sel)
                qy_reg <= div_q;
            else
                qx_reg <= div_q;
        end
        if (cmd.out_load)
        begin
            world_x      <= world_reg[0];
            world_y      <= world_reg[1];
            world_z      <= world_reg[2];
            screen_x     <= sx_reg;
            screen_y     <= sy_reg;
            screen_depth <= sd_reg;
            in_bounds    <= inb_reg;
            drawn        <= drawn_reg;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/vtp_ctrl.sv
// Controller state machine: sequences the multiply passes, clip, divides and output.
// Depends on vtp_pkg; drives the datapath through vtp_cmd_t.
`default_nettype none

module vtp_ctrl
    import vtp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    input  wire logic      s_cmd,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output vtp_cmd_t       cmd,
    input  wire vtp_stat_t stat
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MODEL = 5'd1;
    localparam logic [4:0] S_GAP1  = 5'd2;
    localparam logic [4:0] S_CAM   = 5'd3;
    localparam logic [4:0] S_GAP2  = 5'd4;
    localparam logic [4:0] S_CLIP  = 5'd5;
    localparam logic [4:0] S_DEN   = 5'd6;
    localparam logic [4:0] S_GAP3  = 5'd7;
    localparam logic [4:0] S_DIVX  = 5'd8;
    localparam logic [4:0] S_WAITX = 5'd9;
    localparam logic [4:0] S_DIVY  = 5'd10;
    localparam logic [4:0] S_WAITY = 5'd11;
    localparam logic [4:0] S_SX    = 5'd12;
    localparam logic [4:0] S_SY    = 5'd13;
    localparam logic [4:0] S_SD    = 5'd14;
    localparam logic [4:0] S_GAP4  = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       mvalid_reg, mvalid_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        cmd           = '0;
        cmd.op        = OP_NONE;
        cmd.row       = cnt_reg[1:0];
        cmd.col       = cnt_reg[3:2];
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = accept;
                cnt_next    = 4'd0;
                if (accept && (s_cmd == CMD_VERTEX))
                    state_next = S_MODEL;
            end
            S_MODEL:
            begin
                cmd.op   = OP_MODEL;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = S_GAP1;
            end
            S_GAP1:  state_next = S_CAM;
            S_CAM:
            begin
                cmd.op   = OP_CAM;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = S_GAP2;
            end
            S_GAP2:  state_next = S_CLIP;
            S_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = stat.drawn ? S_DEN : S_DONE;
            end
            S_DEN:
            begin
                cmd.op     = OP_DEN;
                state_next = S_GAP3;
            end
            S_GAP3:  state_next = S_DIVX;
            S_DIVX:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAITX;
            end
            S_WAITX:
            begin
                if (stat.div_done)
                    state_next = S_DIVY;
            end
            S_DIVY:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_WAITY;
            end
            S_WAITY:
            begin
                cmd.div_sel = 1'b1;
                if (stat.div_done)
                    state_next = S_SX;
            end
            S_SX:
            begin
                cmd.op     = OP_SX;
                state_next = S_SY;
            end
            S_SY:
            begin
                cmd.op     = OP_SY;
                state_next = S_SD;
            end
            S_SD:
            begin
                cmd.op     = OP_SD;
                state_next = S_GAP4;
            end
            S_GAP4:  state_next = S_DONE;
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= 4'd0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

`ifndef ASSERT_OFF
    a_vertex_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_cmd == CMD_VERTEX)) |=> (state_reg == S_MODEL))
        else $error("Vertex request did not start the model pass.");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!mvalid_reg || m_tready))
        else $error("Result register loaded while a result was still held.");
    a_divx_to_divy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_WAITX) && stat.div_done) |=> (state_reg == S_DIVY))
        else $error("Second divide did not follow the first.");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> ((state_reg == S_WAITX) || (state_reg == S_WAITY)))
        else $error("Divider finished outside a wait state.");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/vertex_transform_project.sv
// Top level of the vertex transform and perspective projection block.
// Depends on vtp_pkg, vtp_ctrl and vtp_dp.
//
// A load request writes one Q16.16 entry of the model or camera matrix and leaves
// the input open. A vertex request runs two 16-step passes through one shared 33x32
// multiplier, a clip step, and, if the vertex is drawn, two divides on a radix-2
// divider, one after the other; the input stays closed while a vertex is in work,
// and the result turns valid in the cycle in which the input opens again. The
// result sits in an output register, so a new request is taken while it waits;
// only a result that is still held when the next one is done stalls the block.
`default_nettype none

module vertex_transform_project
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // entry_index, entry_value, vertex_x, vertex_y, vertex_z, zero pad
    input  wire logic [135:0]          s_axis_tdata,
    // cmd, matrix_select
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // world_x, world_y, world_z, screen_x, screen_y, screen_depth, zero pad
    output logic [((96 + 3 * SCREEN_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // in_bounds, drawn
    output logic [1:0]                 m_axis_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]           cfg_data
);

    vtp_cmd_t  cmd;
    vtp_stat_t stat;

    logic signed [31:0]             world_x, world_y, world_z;
    logic signed [SCREEN_BITS-1:0]  screen_x, screen_y, screen_depth;
    logic                           in_bounds, drawn;

    assign cfg_ready = 1'b1;

    vtp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_cmd    (s_axis_tuser[0]),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    vtp_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .SCREEN_BITS (SCREEN_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_idx        (cfg_index),
        .cfg_wdata      (cfg_data),
        .in_cmd         (s_axis_tuser[0]),
        .in_msel        (s_axis_tuser[1]),
        .in_entry_index (s_axis_tdata[3:0]),
        .in_entry_value (s_axis_tdata[35:4]),
        .in_vx          (s_axis_tdata[67:36]),
        .in_vy          (s_axis_tdata[99:68]),
        .in_vz          (s_axis_tdata[131:100]),
        .world_x        (world_x),
        .world_y        (world_y),
        .world_z        (world_z),
        .screen_x       (screen_x),
        .screen_y       (screen_y),
        .screen_depth   (screen_depth),
        .in_bounds      (in_bounds),
        .drawn          (drawn)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[31:0]  = world_x;
        m_axis_tdata[63:32] = world_y;
        m_axis_tdata[95:64] = world_z;
        m_axis_tdata[96 +: SCREEN_BITS]                   = screen_x;
        m_axis_tdata[96 + SCREEN_BITS +: SCREEN_BITS]     = screen_y;
        m_axis_tdata[96 + 2 * SCREEN_BITS +: SCREEN_BITS] = screen_depth;
    end

    assign m_axis_tuser = {drawn, in_bounds};

endmodule

`default_nettype wire

>>> verif/vertex_transform_project_test.sv
// Testbench for vertex_transform_project: matrix loads and vertex requests against
// a built-in fixed-point predictor, with random idling on both stream sides.
// Depends on vtp_pkg and the vertex_transform_project RTL.
`default_nettype none

module vertex_transform_project_test;
    import vtp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int SB = SCREEN_BITS_DEF;
    localparam int OW = ((96 + 3 * SB + 7) / 8) * 8;

    typedef struct packed {
        logic [1:0]   user;
        logic [135:0] data;
    } request_t;

    typedef struct packed {
        logic signed [31:0] wx, wy, wz;
        logic signed [15:0] sx, sy, sd;
        logic               inb, drawn;
    } vertex_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    vertex_transform_project i_dut (.*);

    always #1 clk = ~clk;

    request_t pending_requests[$];
    vertex_result_t expected_vertices[$];
    int errors = 0;
    int send_idle_pct = 9;
    int recv_stall_pct = 57;

    longint model_m[16], camera_m[16];
    longint focal, xscale, xoff, yscale, yoff, dscale;
    bit reject;

    function automatic longint sat_to(longint v, int bits);
        longint hi, lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        return (a * b) >>> FB;
    endfunction

    function automatic longint fix_div(longint num, longint den);
        longint n;
        n = num * (longint'(1) << FB);
        if (den == 0)
            return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
        return sat_to(n / den, 32);
    endfunction

    function automatic longint pixel(longint v);
        return sat_to(v / (longint'(1) << FB), SB);
    endfunction

    task automatic project_vertex(input request_t r);
        longint obj[4], world[4], cam[4];
        longint acc, z, den, one;
        vertex_result_t e;
        one = longint'(1) << FB;
        if (r.user[0] == CMD_LOAD)
        begin
            if (r.user[1] == SEL_CAMERA)
                camera_m[r.data[3:0]] = longint'($signed(r.data[35:4]));
            else
                model_m[r.data[3:0]] = longint'($signed(r.data[35:4]));
            return;
        end
        obj[0] = longint'($signed(r.data[67:36]));
        obj[1] = longint'($signed(r.data[99:68]));
        obj[2] = longint'($signed(r.data[131:100]));
        obj[3] = one;
        for (int c = 0; c < 4; c++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += fix_mul(obj[k], model_m[k * 4 + c]);
            world[c] = sat_to(acc, 32);
        end
        for (int c = 0; c < 4; c++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += fix_mul(world[k], camera_m[k * 4 + c]);
            cam[c] = sat_to(acc, 32);
        end
        e = '0;
        e.wx = 32'(world[0]);
        e.wy = 32'(world[1]);
        e.wz = 32'(world[2]);
        z = cam[2];
        e.inb = (z >= -50 * one) && (z < -one);
        e.drawn = e.inb || !reject;
        if (z > -one)
            z = -one;
        if (e.drawn)
        begin
            den = sat_to(fix_mul(-focal, z), 32);
            e.sx = 16'(pixel(fix_mul(fix_div(cam[0], den), xscale) + xoff));
            e.sy = 16'(pixel(fix_mul(fix_div(cam[1], den), yscale) + yoff));
            e.sd = 16'(pixel(fix_mul(z, dscale)));
        end
        expected_vertices.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // Driver: requests leave the queue in order; prediction happens on acceptance.
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            project_vertex(request_t'({s_axis_tuser, s_axis_tdata}));
            void'(pending_requests.pop_front());
        end
        if (rst_n && pending_requests.size() > 0
            && (s_axis_tvalid && !s_axis_tready ? 1 : $urandom_range(99) >= send_idle_pct))
        begin
            if (s_axis_tvalid && s_axis_tready && pending_requests.size() == 0)
                s_axis_tvalid <= 1'b0;
            else
            begin
                s_axis_tvalid <= 1'b1;
                {s_axis_tuser, s_axis_tdata} <= pending_requests[0];
            end
        end
        else if (!(s_axis_tvalid && !s_axis_tready))
            s_axis_tvalid <= 1'b0;
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: each accepted result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        vertex_result_t g, e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            g.wx = m_axis_tdata[31:0];
            g.wy = m_axis_tdata[63:32];
            g.wz = m_axis_tdata[95:64];
            g.sx = m_axis_tdata[111:96];
            g.sy = m_axis_tdata[127:112];
            g.sd = m_axis_tdata[143:128];
            g.inb = m_axis_tuser[0];
            g.drawn = m_axis_tuser[1];
            if (expected_vertices.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = expected_vertices.pop_front();
                if (g.wx !== e.wx) report_mismatch("world_x", g.wx, e.wx);
                if (g.wy !== e.wy) report_mismatch("world_y", g.wy, e.wy);
                if (g.wz !== e.wz) report_mismatch("world_z", g.wz, e.wz);
                if (g.sx !== e.sx) report_mismatch("screen_x", g.sx, e.sx);
                if (g.sy !== e.sy) report_mismatch("screen_y", g.sy, e.sy);
                if (g.sd !== e.sd) report_mismatch("screen_depth", g.sd, e.sd);
                if (g.inb !== e.inb) report_mismatch("in_bounds", g.inb, e.inb);
                if (g.drawn !== e.drawn) report_mismatch("drawn", g.drawn, e.drawn);
            end
        end
    end

    function automatic request_t load_req(bit sel, logic [3:0] idx, logic [31:0] v);
        request_t r;
        r = '0;
        r.user = {sel, CMD_LOAD};
        r.data[3:0] = idx;
        r.data[35:4] = v;
        return r;
    endfunction

    function automatic request_t vertex_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        request_t r;
        r = '0;
        r.user = {logic'($urandom_range(1)), CMD_VERTEX};
        r.data[35:0] = {$urandom, 4'($urandom)};
        r.data[131:36] = {z, y, x};
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(20 << FB)) - (10 << FB));
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(4 << FB)) - (2 << FB));
        endcase
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(4 << FB)) - (2 << FB));
            2: return 32'h0001_0000;
            3: return 32'hffff_0000;
            default: return 32'($signed($urandom_range(1 << FB)) - (1 << (FB - 1)));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FOCAL:  focal = longint'($signed(v));
            CFG_XSCALE: xscale = longint'($signed(v));
            CFG_XOFF:   xoff = longint'($signed(v));
            CFG_YSCALE: yscale = longint'($signed(v));
            CFG_YOFF:   yoff = longint'($signed(v));
            CFG_DSCALE: dscale = longint'($signed(v));
            CFG_REJECT: reject = v[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 20)
                pending_requests.push_back(load_req(1'($urandom_range(1)), 4'($urandom),
                                                    rand_entry()));
            else
                pending_requests.push_back(vertex_req(rand_coord(), rand_coord(),
                                                      rand_coord()));
        end
        drain();
    endtask

    // Perspective-style camera: z is pushed into the clip range for most vertices.
    task automatic load_camera_view();
        pending_requests.push_back(load_req(SEL_CAMERA, 4'd14, 32'hfff6_0000));
        pending_requests.push_back(load_req(SEL_CAMERA, 4'd10, 32'h0002_0000));
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            model_m[i] = (i % 5 == 0) ? (longint'(1) << FB) : 0;
            camera_m[i] = model_m[i];
        end
        focal = 1 << FB;
        xscale = focal;
        yscale = focal;
        dscale = focal;
        xoff = 0;
        yoff = 0;
        reject = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity matrices, near-plane clamp, extremes, zero divisor.
        pending_requests.push_back(vertex_req(32'h0001_0000, 32'h0002_0000, 32'hfffb_0000));
        pending_requests.push_back(vertex_req(32'h0, 32'h0, 32'h0));
        pending_requests.push_back(vertex_req(32'h8000_0000, 32'h7fff_ffff, 32'hffce_0000));
        pending_requests.push_back(vertex_req(32'h7fff_ffff, 32'h8000_0000, 32'hffcd_ffff));
        pending_requests.push_back(vertex_req(32'hffff_ffff, 32'h1, 32'hffff_0000));
        pending_requests.push_back(vertex_req(32'h0003_0000, 32'hfffd_0000, 32'h8000_0000));
        pending_requests.push_back(load_req(SEL_MODEL, 4'd12, 32'h0001_8000));
        pending_requests.push_back(load_req(SEL_MODEL, 4'd15, 32'h8000_0000));
        pending_requests.push_back(load_req(SEL_CAMERA, 4'd0, 32'h7fff_ffff));
        pending_requests.push_back(vertex_req(32'h0001_0000, 32'h0001_0000, 32'hfff0_0000));
        pending_requests.push_back(load_req(SEL_MODEL, 4'd15, 32'h0001_0000));
        pending_requests.push_back(load_req(SEL_CAMERA, 4'd0, 32'h0001_0000));
        drain();
        write_reg(CFG_FOCAL, 32'h0);
        write_reg(CFG_REJECT, 32'h1);
        pending_requests.push_back(vertex_req(32'h0001_0000, 32'hffff_0000, 32'hfff0_0000));
        pending_requests.push_back(vertex_req(32'h0, 32'h0, 32'hfff0_0000));
        pending_requests.push_back(vertex_req(32'h0005_0000, 32'h0005_0000, 32'h0001_0000));
        pending_requests.push_back(vertex_req(32'h0005_0000, 32'h0005_0000, 32'hff00_0000));
        drain();

        write_reg(CFG_FOCAL, 32'h0002_0000);
        write_reg(CFG_XSCALE, 32'h0140_0000);
        write_reg(CFG_XOFF, 32'h00a0_0000);
        write_reg(CFG_YSCALE, 32'h00f0_0000);
        write_reg(CFG_YOFF, 32'h0078_0000);
        write_reg(CFG_DSCALE, 32'h0100_0000);
        write_reg(CFG_REJECT, 32'h0);
        load_camera_view();
        random_phase(500);

        send_idle_pct = 57;
        recv_stall_pct = 9;
        write_reg(CFG_FOCAL, 32'h7fff_ffff);
        write_reg(CFG_XSCALE, 32'h8000_0000);
        write_reg(CFG_XOFF, 32'h7fff_ffff);
        write_reg(CFG_YSCALE, 32'h7fff_ffff);
        write_reg(CFG_YOFF, 32'h8000_0000);
        write_reg(CFG_DSCALE, 32'h8000_0000);
        write_reg(CFG_REJECT, 32'h1);
        load_camera_view();
        random_phase(450);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_FOCAL, 32'h8000_0000);
        write_reg(CFG_XSCALE, 32'h0000_4000);
        write_reg(CFG_XOFF, 32'hffff_8000);
        write_reg(CFG_YSCALE, 32'hfff0_0000);
        write_reg(CFG_YOFF, 32'h0);
        write_reg(CFG_DSCALE, 32'h0000_0001);
        write_reg(CFG_REJECT, 32'h0);
        random_phase(450);

        write_reg(CFG_FOCAL, 32'h0001_0000);
        write_reg(CFG_XSCALE, 32'h0280_0000);
        write_reg(CFG_DSCALE, 32'h7fff_ffff);
        write_reg(CFG_REJECT, 32'h1);
        load_camera_view();
        random_phase(500);

        if (errors == 0)
            $display("PASS vertex_transform_project");
        else
            $display("FAIL vertex_transform_project");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("FAIL vertex_transform_project");
        $finish;
    end

endmodule

`default_nettype wire
